@@ rtl/wmig_pkg.sv @@
package wmig_pkg;

  localparam int unsigned MaxPointsDefault = 64;
  localparam int unsigned DataW = 32;
  localparam logic [DataW-1:0] WindowWidthReset = 32'd16;

  // Item handed from the loader to the compute engine.
  typedef struct packed {
    logic [DataW-1:0] position;
    logic [DataW-1:0] sample_value;
    logic             last_sample;
  } wmig_item_t;

  function automatic logic signed [DataW-1:0] min_s(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    min_s = (a < b) ? a : b;
  endfunction

endpackage

@@ rtl/windowed_min_irregular_grid.sv @@
// Channel   | Ports                                    | Handshake
// ----------|------------------------------------------|---------------------------
// samples   | position, sample_value, last_sample      | push / full
// results   | window_min, last_result, overflow        | empty / pop
// config    | window_width_data                        | window_width_we
//
// Loading takes one sample per cycle through a two-entry queue into the engine.
// The last sample starts compute: a serial block-number divider for each point
// (bypassed when the position lies below the first), bounds found by pointer
// steps (under 2n steps per set), prefix and suffix sweeps over the points, then
// the results one by one. Reset (rst, synchronous)
// clears the counters and queues. Intake stalls while computing; a low pop holds
// the result sweep.
module windowed_min_irregular_grid #(
  parameter int unsigned MaxPoints = wmig_pkg::MaxPointsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] position,
  input  logic [31:0] sample_value,
  input  logic        last_sample,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] window_min,
  output logic        last_result,
  output logic        overflow,
  input  logic        window_width_we,
  input  logic [31:0] window_width_data
);
  import wmig_pkg::*;

  logic [31:0] window_width;
  wmig_item_t  q_in;
  wmig_item_t  q_out;
  logic        q_empty;
  logic        eng_ready;

  // Hold the window width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= WindowWidthReset;
    end else if (window_width_we) begin
      window_width <= window_width_data;
    end
  end

  assign q_in = '{position: position, sample_value: sample_value, last_sample: last_sample};

  // Decouple sample intake from the compute engine.
  wmig_fifo #(.Width($bits(wmig_item_t))) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (q_in),
    .full  (full),
    .rd    (eng_ready),
    .rdata (q_out),
    .empty (q_empty)
  );

  wmig_engine #(.MaxPoints(MaxPoints)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .window_width (window_width),
    .in_valid     (!q_empty),
    .in_item      (q_out),
    .in_ready     (eng_ready),
    .window_min   (window_min),
    .last_result  (last_result),
    .overflow     (overflow),
    .empty        (empty),
    .pop          (pop)
  );
endmodule

@@ rtl/wmig_fifo.sv @@
module wmig_fifo #(
  parameter int unsigned Width = 65
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [Width-1:0] rdata,
  output logic             empty
);
  logic [Width-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr && !full) begin
        wp <= ~wp;
      end
      if (rd && !empty) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end
endmodule

@@ rtl/wmig_engine.sv @@
module wmig_engine #(
  parameter int unsigned MaxPoints = wmig_pkg::MaxPointsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [31:0]                window_width,
  input  logic                       in_valid,
  input  wmig_pkg::wmig_item_t       in_item,
  output logic                       in_ready,
  output logic [31:0]                window_min,
  output logic                       last_result,
  output logic                       overflow,
  output logic                       empty,
  input  logic                       pop
);
  import wmig_pkg::*;

  localparam int unsigned IdxW  = $clog2(MaxPoints);
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned BlkAW = $clog2(MaxPoints + 2);
  localparam int unsigned BlkW  = 33;

  typedef enum logic [15:0] {
    S_LOAD = 16'b0000_0000_0000_0001,
    S_BLK  = 16'b0000_0000_0000_0010,
    S_BLKD = 16'b0000_0000_0000_0100,
    S_DIV  = 16'b0000_0000_0000_1000,
    S_BND  = 16'b0000_0000_0001_0000,
    S_BNDI = 16'b0000_0000_0010_0000,
    S_BNDL = 16'b0000_0000_0100_0000,
    S_BNDR = 16'b0000_0000_1000_0000,
    S_PRE  = 16'b0000_0001_0000_0000,
    S_PREW = 16'b0000_0010_0000_0000,
    S_SUF  = 16'b0000_0100_0000_0000,
    S_SUFW = 16'b0000_1000_0000_0000,
    S_OUTA = 16'b0001_0000_0000_0000,
    S_OUTB = 16'b0010_0000_0000_0000,
    S_OUTC = 16'b0100_0000_0000_0000,
    S_OUTD = 16'b1000_0000_0000_0000
  } state_t;

  state_t state;

  // Stores with registered read ports; undefined until written.
  logic [31:0]         pos_mem [MaxPoints];
  logic signed [31:0]  val_mem [MaxPoints];
  logic [BlkW-1:0]     blk_mem [MaxPoints+2];
  logic [2*IdxW-1:0]   bnd_mem [MaxPoints];
  logic signed [31:0]  pre_mem [MaxPoints];
  logic signed [31:0]  suf_mem [MaxPoints];

  // Read addresses and read data.
  logic [IdxW-1:0]     pos_ra;
  logic [IdxW-1:0]     val_ra;
  logic [IdxW-1:0]     bnd_ra;
  logic [IdxW-1:0]     pre_ra;
  logic [IdxW-1:0]     suf_ra;
  logic [BlkAW-1:0]    blk_ra0;
  logic [BlkAW-1:0]    blk_ra1;
  logic [31:0]         pos_rd;
  logic signed [31:0]  val_rd;
  logic signed [31:0]  pre_rd;
  logic signed [31:0]  suf_rd;
  logic [BlkW-1:0]     blk_rd0;
  logic [BlkW-1:0]     blk_rd1;
  logic [2*IdxW-1:0]   bnd_rd;

  logic [CntW-1:0]     count;
  logic                dropped;
  logic [CntW-1:0]     i;
  logic [CntW-1:0]     l;
  logic [CntW-1:0]     r;
  logic [BlkW-1:0]     top;
  logic [31:0]         x0;
  logic [31:0]         xi;
  logic signed [31:0]  run;

  // Serial restoring divider for block number.
  logic [31:0] quot;
  logic [32:0] rem;
  logic [5:0]  dstep;
  logic [31:0] dnum;
  logic [31:0] bw;

  // Output register
  logic              ovalid;
  logic [31:0]       omin;
  logic              olast;
  logic              oflow;

  logic [IdxW-1:0]    ii;
  logic [IdxW-1:0]    li;
  logic [IdxW-1:0]    ri;
  logic [33:0]        xi2;
  logic [33:0]        xrd2;
  logic [33:0]        wide_w;
  logic [32:0]        rem_sh;
  logic [IdxW-1:0]    lo_q;
  logic [IdxW-1:0]    hi_q;
  logic               case1;
  logic               blk_eq;
  logic               blk_lt;
  logic               l_adv;
  logic               r_adv;
  logic               new_run;
  logic               out_take;
  logic signed [31:0] run_pick;
  logic signed [31:0] out_pick;

  assign ii     = i[IdxW-1:0];
  assign li     = l[IdxW-1:0];
  assign ri     = r[IdxW-1:0];
  assign xi2    = {1'b0, xi, 1'b0};
  assign xrd2   = {1'b0, pos_rd, 1'b0};
  assign wide_w = {2'b00, window_width};
  assign rem_sh = {rem[31:0], dnum[31]};

  // Pointer steps compare the freshly read position against the held point.
  assign l_adv    = (l + 1'b1 < count) && (xrd2 + wide_w < xi2);
  assign r_adv    = (r < count) && (xrd2 <= xi2 + wide_w);
  assign blk_lt   = (blk_rd0 < blk_rd1);
  assign blk_eq   = (blk_rd0 == blk_rd1);
  assign new_run  = blk_lt || ((state == S_PREW) ? (i == '0) : (i == count));
  assign run_pick = new_run ? val_rd : min_s(val_rd, run);
  assign out_pick = case1 ? pre_rd : (blk_eq ? suf_rd : min_s(pre_rd, suf_rd));
  assign out_take = (state == S_OUTD) && (!ovalid || pop);

  assign in_ready    = (state == S_LOAD);
  assign empty       = !ovalid;
  assign window_min  = omin;
  assign last_result = olast;
  assign overflow    = oflow;

  always_comb begin
    pos_ra  = ii;
    val_ra  = ii;
    bnd_ra  = ii;
    pre_ra  = hi_q;
    suf_ra  = lo_q;
    blk_ra0 = BlkAW'(i);
    blk_ra1 = BlkAW'(i) + BlkAW'(1);
    case (state)
      S_BNDI: pos_ra = li;
      S_BNDL: pos_ra = l_adv ? IdxW'(l + 1'b1) : ri;
      S_BNDR: pos_ra = IdxW'(r + 1'b1);
      S_SUF:  val_ra = IdxW'(i - 1'b1);
      S_OUTB: begin
        blk_ra0 = BlkAW'(bnd_rd[2*IdxW-1:IdxW]) + BlkAW'(1);
        blk_ra1 = BlkAW'(bnd_rd[IdxW-1:0]) + BlkAW'(2);
      end
      S_OUTC: begin
        blk_ra0 = BlkAW'(lo_q);
        blk_ra1 = BlkAW'(hi_q) + BlkAW'(1);
      end
      S_OUTD: begin
        blk_ra0 = BlkAW'(lo_q);
        blk_ra1 = BlkAW'(hi_q) + BlkAW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    pos_rd  <= pos_mem[pos_ra];
    val_rd  <= val_mem[val_ra];
    blk_rd0 <= blk_mem[blk_ra0];
    blk_rd1 <= blk_mem[blk_ra1];
    bnd_rd  <= bnd_mem[bnd_ra];
    pre_rd  <= pre_mem[pre_ra];
    suf_rd  <= suf_mem[suf_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_take) begin
      ovalid <= 1'b1;
      omin   <= out_pick;
      olast  <= (i + 1'b1 == count);
      oflow  <= dropped;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (count < CntW'(MaxPoints)) begin
              pos_mem[count[IdxW-1:0]] <= in_item.position;
              val_mem[count[IdxW-1:0]] <= in_item.sample_value;
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (count == '0) begin
              x0 <= in_item.position;
            end
            if (in_item.last_sample) begin
              blk_mem[0] <= '0;
              i     <= '0;
              top   <= '0;
              bw    <= (window_width == '0) ? 32'd1 : window_width;
              state <= S_BLK;
            end
          end
        end
        S_BLK: begin
          // close the list with the sentinel past the largest block
          if (i == count) begin
            blk_mem[BlkAW'(count) + BlkAW'(1)] <= top + 1'b1;
            i     <= '0;
            l     <= '0;
            r     <= '0;
            state <= S_BND;
          end else begin
            state <= S_BLKD;
          end
        end
        S_BLKD: begin
          if (pos_rd < x0) begin
            blk_mem[BlkAW'(i) + BlkAW'(1)] <= BlkW'(1);
            if (top < BlkW'(1)) begin
              top <= BlkW'(1);
            end
            i     <= i + 1'b1;
            state <= S_BLK;
          end else begin
            dnum  <= pos_rd - x0;
            rem   <= '0;
            quot  <= '0;
            dstep <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          if (rem_sh >= {1'b0, bw}) begin
            rem  <= rem_sh - {1'b0, bw};
            quot <= {quot[30:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[30:0], 1'b0};
          end
          dnum  <= {dnum[30:0], 1'b0};
          dstep <= dstep + 1'b1;
          if (dstep == 6'd32) begin
            blk_mem[BlkAW'(i) + BlkAW'(1)] <= {1'b0, quot} + 1'b1;
            if (top < {1'b0, quot} + 1'b1) begin
              top <= {1'b0, quot} + 1'b1;
            end
            rem   <= '0;
            quot  <= quot;
            dnum  <= dnum;
            i     <= i + 1'b1;
            state <= S_BLK;
          end
        end
        S_BND: begin
          if (i == count) begin
            i     <= '0;
            state <= S_PRE;
          end else begin
            state <= S_BNDI;
          end
        end
        S_BNDI: begin
          xi    <= pos_rd;
          state <= S_BNDL;
        end
        S_BNDL: begin
          // advance the left pointer until it settles
          if (l_adv) begin
            l <= l + 1'b1;
          end else begin
            state <= S_BNDR;
          end
        end
        S_BNDR: begin
          // advance the right pointer, then store both bounds
          if (r_adv) begin
            r <= r + 1'b1;
          end else begin
            bnd_mem[ii] <= {li, IdxW'(r - 1'b1)};
            i     <= i + 1'b1;
            state <= S_BND;
          end
        end
        S_PRE: begin
          if (i == count) begin
            state <= S_SUF;
          end else begin
            state <= S_PREW;
          end
        end
        S_PREW: begin
          pre_mem[ii] <= run_pick;
          run   <= run_pick;
          i     <= i + 1'b1;
          state <= S_PRE;
        end
        S_SUF: begin
          if (i == '0) begin
            state <= S_OUTA;
          end else begin
            state <= S_SUFW;
          end
        end
        S_SUFW: begin
          suf_mem[IdxW'(i - 1'b1)] <= run_pick;
          run   <= run_pick;
          i     <= i - 1'b1;
          state <= S_SUF;
        end
        S_OUTA: begin
          if (i == count) begin
            count   <= '0;
            dropped <= 1'b0;
            state   <= S_LOAD;
          end else begin
            state <= S_OUTB;
          end
        end
        S_OUTB: begin
          lo_q  <= bnd_rd[2*IdxW-1:IdxW];
          hi_q  <= bnd_rd[IdxW-1:0];
          state <= S_OUTC;
        end
        S_OUTC: begin
          case1 <= blk_eq;
          state <= S_OUTD;
        end
        S_OUTD: begin
          // hold the read addresses until the output register frees up
          if (out_take) begin
            i     <= i + 1'b1;
            state <= S_OUTA;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = wmig_pkg::MaxPointsDefault;

  // One sample as the sender drives it.
  typedef struct {
    logic [31:0] pos;
    logic [31:0] val;
    logic        last;
  } sample_t;

  typedef struct {
    logic [31:0] wmin;
    logic        last;
    logic        ovf;
  } window_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [31:0] position = '0;
  logic [31:0] sample_value = '0;
  logic        last_sample = 1'b0;
  logic        pop = 1'b0;
  logic        window_width_we = 1'b0;
  logic [31:0] window_width_data = '0;
  logic        full, empty, last_result, overflow;
  logic [31:0] window_min;

  windowed_min_irregular_grid dut (
    .clk, .rst, .push, .full, .position, .sample_value, .last_sample,
    .empty, .pop, .window_min, .last_result, .overflow,
    .window_width_we, .window_width_data
  );

  always #10 clk = ~clk;

  // Predictor copy of the block's state.
  logic [31:0]        width_reg = wmig_pkg::WindowWidthReset;
  logic [31:0]        pos_set[Cap];
  logic signed [31:0] val_set[Cap];
  int unsigned        set_count = 0;
  bit                 set_dropped = 0;

  window_result_t     pending_mins[$];
  int                 error_count = 0;
  int                 results_seen = 0;
  int                 sets_closed = 0;
  bit                 stall_ended = 0;

  function automatic logic signed [31:0] lesser(logic signed [31:0] a,
                                                logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  // Work out the window minima of the stored set, van Herk / Gil-Werman style.
  function automatic void predict_window_mins();
    logic [63:0]        blk[Cap + 2];
    int unsigned        lb[Cap], rb[Cap];
    logic signed [31:0] pre[Cap], suf[Cap];
    logic [63:0]        bw, top, xi2, w;
    int unsigned        n, l, r, lo, hi;
    logic signed [31:0] res;
    window_result_t     item;
    n = set_count;
    bw = (width_reg == 0) ? 64'd1 : {32'd0, width_reg};
    w = {32'd0, width_reg};
    top = 0;
    blk[0] = 0;
    for (int i = 0; i < n; i++) begin
      blk[i + 1] = (pos_set[i] < pos_set[0]) ? 64'd1 :
                   ({32'd0, pos_set[i] - pos_set[0]} / bw + 64'd1);
      if (blk[i + 1] > top) top = blk[i + 1];
    end
    blk[n + 1] = top + 1;
    l = 0;
    r = 0;
    for (int i = 0; i < n; i++) begin
      xi2 = {31'd0, pos_set[i], 1'b0};
      while (l + 1 < n && {31'd0, pos_set[l], 1'b0} + w < xi2) l++;
      while (r < n && {31'd0, pos_set[r], 1'b0} <= xi2 + w) r++;
      lb[i] = l;
      rb[i] = r - 1;
    end
    for (int i = 0; i < n; i++)
      pre[i] = (i == 0 || blk[i] < blk[i + 1]) ? val_set[i] : lesser(val_set[i], pre[i - 1]);
    for (int i = n; i > 0; i--)
      suf[i - 1] = (i == n || blk[i] < blk[i + 1]) ? val_set[i - 1] :
                   lesser(val_set[i - 1], suf[i]);
    for (int i = 0; i < n; i++) begin
      lo = lb[i];
      hi = rb[i];
      if (blk[lo + 1] == blk[hi + 2]) res = pre[hi];
      else if (blk[lo] == blk[hi + 1]) res = suf[lo];
      else res = lesser(pre[hi], suf[lo]);
      item.wmin = res;
      item.last = (i + 1 == n);
      item.ovf = set_dropped;
      pending_mins.push_back(item);
    end
    set_count = 0;
    set_dropped = 0;
    sets_closed++;
  endfunction

  function automatic void absorb_sample(sample_t s);
    if (set_count < Cap) begin
      pos_set[set_count] = s.pos;
      val_set[set_count] = s.val;
      set_count++;
    end else begin
      set_dropped = 1;
    end
    if (s.last) predict_window_mins();
  endfunction

  // Drive one sample; hold it until the block takes it. The caller drops push.
  task automatic send_sample(sample_t s);
    push <= 1'b1;
    position <= s.pos;
    sample_value <= s.val;
    last_sample <= s.last;
    @(posedge clk);
    while (full) @(posedge clk);
    absorb_sample(s);
  endtask

  // Random gap after a burst of samples.
  int burst_left = 0;
  task automatic maybe_gap();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (pending_mins.size() != 0) @(posedge clk);
    // The block may still be sweeping after the final result; give it room.
    repeat (40) @(posedge clk);
  endtask

  task automatic write_width(logic [31:0] wv);
    window_width_we <= 1'b1;
    window_width_data <= wv;
    @(posedge clk);
    window_width_we <= 1'b0;
    width_reg = wv;
  endtask

  // Send a whole set with nondecreasing positions starting at base, or random ones if shuffle.
  task automatic send_random_set(int unsigned n, logic [31:0] base, int unsigned step_max,
                                 bit shuffle);
    sample_t     s;
    logic [31:0] p;
    p = base;
    for (int i = 0; i < n; i++) begin
      s.pos = shuffle ? $urandom() : p;
      case ($urandom_range(0, 3))
        0: s.val = $urandom_range(0, 15) - 8;
        1: s.val = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15) :
                                          32'h7fff_fff0 + $urandom_range(0, 15);
        default: s.val = $urandom();
      endcase
      s.last = (i + 1 == n);
      maybe_gap();
      send_sample(s);
      p = p + $urandom_range(0, step_max);
    end
  endtask

  // Receiver: stall on a pattern of its own, compare against the oldest expectation.
  int stall_phase = 0;
  always @(posedge clk) begin
    window_result_t exp_item;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (pending_mins.size() == 0) begin
        $error("result with nothing expected: window_min=%0d", $signed(window_min));
        error_count++;
      end else begin
        exp_item = pending_mins.pop_front();
        if (window_min !== exp_item.wmin) begin
          $error("window_min: expected %0d, got %0d", $signed(exp_item.wmin),
                 $signed(window_min));
          error_count++;
        end
        if (last_result !== exp_item.last) begin
          $error("last_result: expected %0b, got %0b", exp_item.last, last_result);
          error_count++;
        end
        if (overflow !== exp_item.ovf) begin
          $error("overflow: expected %0b, got %0b", exp_item.ovf, overflow);
          error_count++;
        end
      end
    end
    stall_phase <= stall_phase + 1;
    // Stretches of free flow alternate with a stuttering pattern and random stalls.
    if (stall_ended) pop <= 1'b1;
    else if (stall_phase[8]) pop <= 1'b1;
    else if (stall_phase[7]) pop <= (stall_phase % 3) != 0;
    else pop <= ($urandom_range(0, 3) != 0);
  end

  // Directed stimulus: the obvious answers are typed in and cross-checked.
  typedef struct {
    logic [31:0] pos;
    logic [31:0] val;
    logic        last;
    bit          has_exp;
    logic [31:0] exp_min;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    // single-point set: its own value
    '{32'd0,          32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'hffff_ffff,  32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
    // two points far apart: each sees only itself
    '{32'd0,          32'd5,         1'b0, 1'b1, 32'd5},
    '{32'hffff_ffff,  32'hffff_fffb, 1'b1, 1'b1, 32'hffff_fffb},
    // three points close together: all see the smallest
    '{32'd100,        32'd7,         1'b0, 1'b1, 32'h8000_0000},
    '{32'd101,        32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
    '{32'd102,        32'h7fff_ffff, 1'b1, 1'b1, 32'h8000_0000},
    // window edges: exactly half a window away is inside, one more is outside
    '{32'd1000,       32'd9,         1'b0, 1'b0, 32'd0},
    '{32'd1008,       32'd3,         1'b0, 1'b0, 32'd0},
    '{32'd1017,       32'd1,         1'b0, 1'b0, 32'd0},
    '{32'd1024,       32'd4,         1'b0, 1'b0, 32'd0},
    '{32'd1040,       32'h8000_0001, 1'b1, 1'b0, 32'd0},
    // unordered positions
    '{32'd500,        32'd2,         1'b0, 1'b0, 32'd0},
    '{32'd10,         32'd1,         1'b0, 1'b0, 32'd0},
    '{32'd505,        32'd0,         1'b1, 1'b0, 32'd0}
  };

  initial begin
    sample_t s;
    int      first_row;
    int      width_pick;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset width (16) for the directed table.
    first_row = 0;
    foreach (directed_rows[k]) begin
      s.pos = directed_rows[k].pos;
      s.val = directed_rows[k].val;
      s.last = directed_rows[k].last;
      send_sample(s);
      if (directed_rows[k].last) begin
        // Compare typed-in answers with the predictor before they are checked.
        for (int j = first_row; j <= k; j++) begin
          if (directed_rows[j].has_exp &&
              pending_mins[pending_mins.size() - 1 - (k - j)].wmin !== directed_rows[j].exp_min) begin
            $error("window_min: expected %0d, predicted %0d",
                   $signed(directed_rows[j].exp_min),
                   $signed(pending_mins[pending_mins.size() - 1 - (k - j)].wmin));
            error_count++;
          end
        end
        first_row = k + 1;
      end
    end
    drain_and_settle();

    // Zero width: only equal positions share a window.
    write_width(32'd0);
    send_random_set(6, 32'd50, 1, 0);
    drain_and_settle();

    // Overflow: fill past capacity, last sample dropped but still closes the set.
    write_width(32'd64);
    send_random_set(Cap + 3, 32'd0, 9, 0);
    drain_and_settle();

    // Widest window: everything lands in one block.
    write_width(32'hffff_ffff);
    send_random_set(5, 32'hffff_ff00, 60, 0);
    drain_and_settle();

    // Random part: mostly ordered sets of small size, some noise and unordered sets.
    for (int setn = 0; setn < 6; setn++) begin
      width_pick = $urandom_range(0, 5);
      case (width_pick)
        0: write_width(32'd0);
        1: write_width(32'hffff_ffff);
        2: write_width($urandom());
        default: write_width($urandom_range(1, 200));
      endcase
      if (setn % 3 == 2) send_random_set($urandom_range(1, 4), $urandom(), 0, 1);
      else send_random_set($urandom_range(1, 8), $urandom(), $urandom_range(0, 120), 0);
      drain_and_settle();
    end

    stall_ended = 1;
    repeat (200) @(posedge clk);
    if (pending_mins.size() != 0) begin
      $error("%0d window minima never arrived", pending_mins.size());
      error_count++;
    end
    $display("Covered %0d sets and %0d results over zero, small, random and full widths,",
             sets_closed, results_seen);
    $display("including overflow, unordered positions and window-edge cases.");
    if (error_count == 0) begin
      $display("** windowed_min_irregular_grid: PASSED **");
    end else begin
      $display("** windowed_min_irregular_grid: FAILED **");
    end
    $finish;
  end

  // Generous guard against a hung handshake.
  initial begin
    #(20ms);
    $display("** windowed_min_irregular_grid: FAILED **");
    $finish;
  end

endmodule
